[hdl/epdf_pkg.sv]
// echo pulse distance filter: shared constants and types
// used by every module of the block, depends on nothing
package epdf_pkg;

  // field widths
  localparam int unsigned CAP_W  = 16;
  localparam int unsigned DIST_W = 17;

  // capture value that the timer wraps at
  localparam logic [CAP_W-1:0] WRAP_TOP = 16'hFFFF;

  // reset value of the step limit register
  localparam logic [DIST_W-1:0] LIMIT_RESET = 17'd200;

  // distance scale: width * 17 / 10, done as width * (17 * ceil(2^25 / 10)) >> 25
  // (exact for any width * 17 below 2^21)
  localparam int unsigned DIST_NUM   = 17;
  localparam int unsigned DIST_DEN   = 10;
  localparam int unsigned DIST_SH    = 25;
  localparam int unsigned DIST_K_W   = 26;
  localparam int unsigned DIST_RECIP = ((32'd1 << DIST_SH) + DIST_DEN - 1) / DIST_DEN;
  localparam logic [DIST_K_W-1:0] DIST_K = DIST_K_W'(DIST_RECIP * DIST_NUM);

  // largest distance a pulse can give
  localparam logic [DIST_W-1:0] DIST_MAX = 17'd111409;

  // one word pushed into the window chain
  typedef struct packed {
    logic              push;
    logic [DIST_W-1:0] data;
  } epdf_push_t;

endpackage

[hdl/epdf_cell.sv]
// one window cell: holds a stored distance and hands it to its neighbor on a push
// depends on epdf_pkg
module epdf_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift_en,
  input  logic [epdf_pkg::DIST_W-1:0] d,
  output logic [epdf_pkg::DIST_W-1:0] q
);

  // entry register, cleared at reset so the window starts all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift_en) begin
      q <= d;
    end
  end

endmodule

[hdl/epdf_window.sv]
// distance window: a row of cells holding the last DEPTH distances plus the running sum
// depends on epdf_pkg and epdf_cell
module epdf_window #(
  parameter  int unsigned DEPTH = 8,
  localparam int unsigned SUM_W = epdf_pkg::DIST_W + $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  epdf_pkg::epdf_push_t   push,
  output logic [SUM_W-1:0]       sum
);

  logic [epdf_pkg::DIST_W-1:0] q [DEPTH];
  logic [SUM_W-1:0]            sum_next;

  // chain of cells, the newest distance enters at cell 0, the oldest leaves the last cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      epdf_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (push.push),
        .d        (push.data),
        .q        (q[i])
      );
    end else begin : g_body
      epdf_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (push.push),
        .d        (q[i-1]),
        .q        (q[i])
      );
    end
  end

  // running sum: drop the entry that falls off the end, add the new one
  assign sum_next = sum - SUM_W'(q[DEPTH-1]) + SUM_W'(push.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (push.push) begin
      sum <= sum_next;
    end
  end

endmodule

[hdl/echo_pulse_distance_filter_unit.sv]
// Echo pulse distance filter. One edge word per cycle is accepted unless the pipeline
// stalls. A rising edge arms the block and a falling edge closes the pulse; edges in the
// wrong phase are dropped. A closed pulse gives one result word, formed in registered steps:
// width, scaled distance, outlier check with window push, then the new average. The outlier
// check reads the average of the previous pulse, which is up to date because the check waits
// while stage three still holds a word, so also while the output register is stalled. Reset
// clears the whole window. Depends on epdf_pkg and epdf_window.
module echo_pulse_distance_filter_unit #(
  parameter int unsigned FILTER_DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [epdf_pkg::DIST_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [epdf_pkg::CAP_W-1:0]   capture_value,
  input  logic                         pin_level,
  input  logic                         warmed_up,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [epdf_pkg::DIST_W-1:0]  distance_mm,
  output logic [epdf_pkg::DIST_W-1:0]  average_mm,
  output logic                         replaced
);

  localparam int unsigned DEPTH_LOG = $clog2(FILTER_DEPTH);
  localparam int unsigned SUM_W     = epdf_pkg::DIST_W + DEPTH_LOG;
  localparam int unsigned AVG_SH    = SUM_W + DEPTH_LOG;
  localparam int unsigned PROD_W    = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] AVG_MUL =
    (SUM_W+1)'(((64'd1 << AVG_SH) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));
  localparam logic [SUM_W-1:0] SUM_MAX =
    SUM_W'(64'(FILTER_DEPTH) * 64'(epdf_pkg::DIST_MAX));
  localparam int unsigned DPROD_W = epdf_pkg::CAP_W + epdf_pkg::DIST_K_W;

  // control state
  logic                        edge_phase;
  logic [epdf_pkg::DIST_W-1:0] step_limit;
  logic [epdf_pkg::DIST_W-1:0] current_average;
  logic                        r1_valid, r2_valid, r3_valid;

  // payload
  logic [epdf_pkg::CAP_W-1:0]  rise_capture;
  logic [epdf_pkg::CAP_W-1:0]  r1_width;
  logic                        r1_warm;
  logic [epdf_pkg::DIST_W-1:0] r2_dist;
  logic                        r2_warm;
  logic [epdf_pkg::DIST_W-1:0] r3_dist;
  logic                        r3_rep;

  logic                        in_fire, pulse_end;
  logic                        r1_move, r2_move, r3_move;
  logic [epdf_pkg::CAP_W-1:0]  width_in;
  logic [DPROD_W-1:0]          dist_prod;
  logic [epdf_pkg::DIST_W-1:0] dist_raw;
  logic [epdf_pkg::DIST_W-1:0] dist_diff;
  logic                        is_outlier;
  logic [epdf_pkg::DIST_W-1:0] dist_kept;
  logic [SUM_W-1:0]            window_sum;
  logic [PROD_W-1:0]           avg_prod;
  logic [epdf_pkg::DIST_W-1:0] avg_new;
  epdf_pkg::epdf_push_t        win_push;

  // stage moves; the outlier stage waits until the previous result has left stage three,
  // so the average it reads is always up to date
  assign r3_move  = r3_valid && (!out_valid || out_ready);
  assign r2_move  = r2_valid && !r3_valid;
  assign r1_move  = r1_valid && (!r2_valid || r2_move);
  assign in_ready = !r1_valid || r1_move;
  assign in_fire  = in_valid && in_ready;
  assign pulse_end = in_fire && edge_phase && !pin_level;

  // pulse width, with the wrap case when the falling capture is not past the rising one
  always_comb begin
    if (capture_value > rise_capture) begin
      width_in = capture_value - rise_capture;
    end else begin
      width_in = (epdf_pkg::WRAP_TOP - rise_capture) + capture_value;
    end
  end

  // width to millimetres
  assign dist_prod = DPROD_W'(r1_width) * DPROD_W'(epdf_pkg::DIST_K);
  assign dist_raw  = dist_prod[epdf_pkg::DIST_SH +: epdf_pkg::DIST_W];

  // outlier check against the previous average
  always_comb begin
    if (r2_dist >= current_average) begin
      dist_diff = r2_dist - current_average;
    end else begin
      dist_diff = current_average - r2_dist;
    end
    is_outlier = r2_warm && (dist_diff > step_limit);
    dist_kept  = is_outlier ? current_average : r2_dist;
  end

  assign win_push.push = r2_move;
  assign win_push.data = dist_kept;

  // window of stored distances; while stage three holds a word the sum is the one
  // right after that word's push, since no other push can happen meanwhile
  epdf_window #(
    .DEPTH (FILTER_DEPTH)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .push (win_push),
    .sum  (window_sum)
  );

  // average = window sum / depth by reciprocal multiply
  assign avg_prod = PROD_W'(window_sum) * PROD_W'(AVG_MUL);
  assign avg_new  = avg_prod[AVG_SH +: epdf_pkg::DIST_W];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_phase      <= 1'b0;
      step_limit      <= epdf_pkg::LIMIT_RESET;
      current_average <= '0;
      r1_valid        <= 1'b0;
      r2_valid        <= 1'b0;
      r3_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        step_limit <= cfg_wr_data;
      end
      if (in_fire) begin
        if (!edge_phase && pin_level) begin
          edge_phase <= 1'b1;
        end else if (edge_phase && !pin_level) begin
          edge_phase <= 1'b0;
        end
      end
      if (pulse_end) begin
        r1_valid <= 1'b1;
      end else if (r1_move) begin
        r1_valid <= 1'b0;
      end
      if (r1_move) begin
        r2_valid <= 1'b1;
      end else if (r2_move) begin
        r2_valid <= 1'b0;
      end
      if (r2_move) begin
        r3_valid <= 1'b1;
      end else if (r3_move) begin
        r3_valid <= 1'b0;
      end
      if (r3_move) begin
        out_valid       <= 1'b1;
        current_average <= avg_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire && !edge_phase && pin_level) begin
      rise_capture <= capture_value;
    end
    if (pulse_end) begin
      r1_width <= width_in;
      r1_warm  <= warmed_up;
    end
    if (r1_move) begin
      r2_dist <= dist_raw;
      r2_warm <= r1_warm;
    end
    if (r2_move) begin
      r3_dist <= dist_kept;
      r3_rep  <= is_outlier;
    end
    if (r3_move) begin
      distance_mm <= r3_dist;
      average_mm  <= avg_new;
      replaced    <= r3_rep;
    end
  end

`ifndef SYNTHESIS
  // results stay within the range a pulse can give
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (distance_mm <= epdf_pkg::DIST_MAX && average_mm <= epdf_pkg::DIST_MAX))
    else $error("result out of range");

  // running sum never exceeds a full window of largest distances
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    window_sum <= SUM_MAX)
    else $error("window sum out of range");

  // a new result word only comes out of stage three
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(r3_valid))
    else $error("result word without a pulse behind it");

  // the outlier stage never runs while the previous average is still being formed
  a_avg_order: assert property (@(posedge clk) disable iff (rst)
    r2_move |-> !r3_valid)
    else $error("outlier check read a stale average");
`endif

endmodule

[verif/tb.sv]
// testbench for the echo pulse distance filter: random and directed edge words,
// checked word by word against an in-bench predictor of the filter
// depends on epdf_pkg and echo_pulse_distance_filter_unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP_W     = epdf_pkg::CAP_W;
  localparam int unsigned DIST_W    = epdf_pkg::DIST_W;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned HOLD_LONG = 400;
  localparam int unsigned SETTLE    = 8;

  // one edge word and one result word
  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic             level;
    logic             warm;
  } pin_event_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_mm;
    logic [DIST_W-1:0] avg;
    logic              rep;
  } echo_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [DIST_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CAP_W-1:0]  capture_value = '0;
  logic              pin_level = 1'b0;
  logic              warmed_up = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DIST_W-1:0] distance_mm;
  logic [DIST_W-1:0] average_mm;
  logic              replaced;

  // stimulus and scoreboard state
  pin_event_t   pending_edges[$];
  echo_result_t echo_results[$];
  int unsigned  words_queued = 0;
  int unsigned  words_taken = 0;
  int unsigned  fails = 0;
  logic         in_taken = 1'b0;
  logic         quiet = 1'b0;
  int unsigned  hold_req = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;
  int unsigned  src_gap = 0;
  int unsigned  sink_gap = 0;

  // predictor state
  logic              armed;
  logic [CAP_W-1:0]  rise_cap;
  logic [DIST_W-1:0] dist_ring[DEPTH];
  int unsigned       ring_slot;
  int unsigned       ring_sum;
  logic [DIST_W-1:0] run_avg;
  logic [DIST_W-1:0] jump_limit;

  echo_pulse_distance_filter_unit #(
    .FILTER_DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .capture_value(capture_value),
    .pin_level    (pin_level),
    .warmed_up    (warmed_up),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance_mm  (distance_mm),
    .average_mm   (average_mm),
    .replaced     (replaced)
  );

  always #6 clk = ~clk;

  // arms on a rising edge, closes a pulse on a falling edge and queues the expected result word
  function automatic void predict_echo(pin_event_t ev);
    int unsigned  width;
    int unsigned  dist_val;
    int unsigned  diff;
    echo_result_t res;
    res.rep = 1'b0;
    if (!armed) begin
      if (ev.level) begin
        rise_cap = ev.cap;
        armed    = 1'b1;
      end
      return;
    end
    if (ev.level) return;
    // wrapped or equal captures count up through the top of the timer
    if (ev.cap > rise_cap) width = int'(ev.cap) - int'(rise_cap);
    else width = (int'(epdf_pkg::WRAP_TOP) - int'(rise_cap)) + int'(ev.cap);
    dist_val = (width * epdf_pkg::DIST_NUM) / epdf_pkg::DIST_DEN;
    // outlier replacement once warmed up
    if (ev.warm) begin
      diff = (dist_val > run_avg) ? dist_val - run_avg : run_avg - dist_val;
      if (diff > jump_limit) begin
        dist_val = run_avg;
        res.rep  = 1'b1;
      end
    end
    ring_slot = (ring_slot + 1) % DEPTH;
    ring_sum  = ring_sum - dist_ring[ring_slot] + dist_val;
    dist_ring[ring_slot] = DIST_W'(dist_val);
    run_avg   = DIST_W'(ring_sum / DEPTH);
    armed     = 1'b0;
    res.dist_mm = DIST_W'(dist_val);
    res.avg   = run_avg;
    echo_results.push_back(res);
  endfunction

  // edge word driver, fed from pending_edges
  always @(negedge clk) begin : drive_edges
    logic       nxt_valid;
    pin_event_t nxt_word;
    nxt_valid = in_valid;
    nxt_word  = '{capture_value, pin_level, warmed_up};
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (src_gap != 0) begin
        src_gap--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(0, 11);
      end else if (pending_edges.size() != 0) begin
        nxt_word  = pending_edges.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid      <= nxt_valid;
    capture_value <= nxt_word.cap;
    pin_level     <= nxt_word.level;
    warmed_up     <= nxt_word.warm;
  end

  // result receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin : drive_ready
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst) begin
      nxt_ready = 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LONG;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (sink_gap != 0) begin
      sink_gap--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 11);
    end else begin
      nxt_ready = 1'b1;
    end
    out_ready <= nxt_ready;
  end

  // monitor: checks result words, feeds the predictor with accepted edge words
  always @(posedge clk) begin : watch_ports
    echo_result_t want;
    pin_event_t   ev;
    if (rst) begin
      armed      = 1'b0;
      rise_cap   = '0;
      for (int i = 0; i < DEPTH; i++) dist_ring[i] = '0;
      ring_slot  = DEPTH - 1;
      ring_sum   = 0;
      run_avg    = '0;
      jump_limit = epdf_pkg::LIMIT_RESET;
      in_taken  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (echo_results.size() == 0) begin
          $error("result word with none expected: distance_mm %0d average_mm %0d replaced %0d",
                 distance_mm, average_mm, replaced);
          fails++;
        end else begin
          want = echo_results.pop_front();
          if (distance_mm !== want.dist_mm) begin
            $error("distance_mm expected %0d got %0d", want.dist_mm, distance_mm);
            fails++;
          end
          if (average_mm !== want.avg) begin
            $error("average_mm expected %0d got %0d", want.avg, average_mm);
            fails++;
          end
          if (replaced !== want.rep) begin
            $error("replaced expected %0d got %0d", want.rep, replaced);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        ev = '{capture_value, pin_level, warmed_up};
        words_taken++;
        predict_echo(ev);
      end
      if (cfg_wr_en) jump_limit = cfg_wr_data;
      in_taken <= in_valid && in_ready;
    end
  end

  task automatic queue_word(input logic [CAP_W-1:0] cap, input logic level,
                            input logic warm);
    pin_event_t ev;
    ev.cap   = cap;
    ev.level = level;
    ev.warm  = warm;
    pending_edges.push_back(ev);
    words_queued++;
  endtask

  // mostly clean rise/fall pairs near a random base width, some noise and broken pairs
  task automatic queue_pulses(input int n_words);
    int unsigned      base;
    int unsigned      w;
    int               added;
    int unsigned      r;
    logic [CAP_W-1:0] rise;
    base  = $urandom_range(300, 30000);
    added = 0;
    while (added < n_words) begin
      r    = $urandom_range(0, 99);
      rise = CAP_W'($urandom);
      if (r < 6) begin
        queue_word(rise, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        added += 1;
      end else begin
        if (r < 16) w = $urandom_range(0, 65535);
        else w = base + $urandom_range(0, 240) - 120;
        queue_word(rise, 1'b1, 1'($urandom_range(0, 1)));
        // rising edge while armed must not move the first capture
        if (r < 10) begin
          queue_word(CAP_W'($urandom), 1'b1, 1'($urandom_range(0, 1)));
          added += 1;
        end
        queue_word(rise + CAP_W'(w), 1'b0, $urandom_range(0, 7) != 0);
        added += 2;
      end
    end
  endtask

  // wait until every word is taken and every result is back, then let the pipe settle
  task automatic wait_drained();
    while (words_taken != words_queued || echo_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under the reset limit
    queue_word(16'd100, 1'b0, 1'b0);     // falling edge while idle
    queue_word(16'd0, 1'b1, 1'b0);
    queue_word(16'd500, 1'b1, 1'b0);     // rising edge while armed
    queue_word(16'd0, 1'b0, 1'b0);       // equal captures
    queue_word(16'hFFFF, 1'b1, 1'b0);
    queue_word(16'hFFFF, 1'b0, 1'b0);    // equal at the top
    queue_word(16'hFFF0, 1'b1, 1'b0);
    queue_word(16'h0010, 1'b0, 1'b0);    // wrapped
    queue_word(16'd1000, 1'b1, 1'b0);
    queue_word(16'd1588, 1'b0, 1'b0);
    queue_word(16'hFFFF, 1'b1, 1'b1);
    queue_word(16'h0000, 1'b0, 1'b0);    // wrap to zero width
    queue_word(16'h0000, 1'b1, 1'b0);
    queue_word(16'hFFFF, 1'b0, 1'b0);    // widest unwrapped pulse
    queue_word(16'h5555, 1'b0, 1'b1);    // falling while idle, warmed up
    queue_word(16'd2000, 1'b1, 1'b1);
    queue_word(16'd2050, 1'b0, 1'b1);    // far below the average: replaced
    queue_word(16'hAAAA, 1'b1, 1'b1);
    queue_word(16'hAAAB, 1'b0, 1'b1);    // one-tick pulse, warmed up
    queue_word(16'h8000, 1'b1, 1'b0);
    queue_word(16'h7FFF, 1'b0, 1'b1);    // wrapped, warmed up
    queue_word(16'h1234, 1'b1, 1'b1);
    queue_word(16'h9234, 1'b0, 1'b1);
    wait_drained();

    write_limit('0);
    queue_pulses(300);
    wait_drained();

    write_limit({DIST_W{1'b1}});
    queue_pulses(300);
    wait_drained();

    // long receiver hold-off while the sender keeps offering words
    write_limit(DIST_W'($urandom_range(0, 131071)));
    queue_pulses(300);
    hold_req++;
    wait_drained();

    write_limit(17'd1000);
    queue_pulses(300);
    wait_drained();

    write_limit(DIST_W'($urandom_range(0, 400)));
    queue_pulses(400);
    wait_drained();

    // closing stretch with no idling on either side
    quiet = 1'b1;
    write_limit(epdf_pkg::LIMIT_RESET);
    queue_pulses(350);
    wait_drained();

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
